// ===== rtl/core/ddwp_pkg.sv =====
// Shared types, constants and helper functions for the waypoint PID core.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ddwp_pkg;

  localparam int FifoDepthDef   = 16;
  localparam int CordicItersDef = 16;

  // Input action codes.
  localparam logic [1:0] ACT_POSE = 2'd0;
  localparam logic [1:0] ACT_WAYPOINT = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // Phase codes.
  localparam logic [1:0] PH_TURN = 2'd0;
  localparam logic [1:0] PH_DRIVE = 2'd1;
  localparam logic [1:0] PH_ROTATE = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // Register indexes.
  localparam logic [2:0] REG_KP_LIN = 3'd0;
  localparam logic [2:0] REG_KI_LIN = 3'd1;
  localparam logic [2:0] REG_KD_LIN = 3'd2;
  localparam logic [2:0] REG_KP_ANG = 3'd3;
  localparam logic [2:0] REG_KI_ANG = 3'd4;
  localparam logic [2:0] REG_KD_ANG = 3'd5;
  localparam logic [2:0] REG_DIST_TH = 3'd6;
  localparam logic [2:0] REG_ANG_TH = 3'd7;

  localparam logic signed [15:0] PI_Q12 = 16'sd12868;
  localparam logic signed [15:0] TWO_PI_Q12 = 16'sd25736;
  localparam logic signed [21:0] HALF_PI_Q16 = 22'sd102944;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic [11:0] DT_Q16 = 12'd3277;
  localparam logic signed [20:0] ILIM_ANG = 21'sd65536;
  localparam logic signed [20:0] ILIM_LIN = 21'sd16384;
  localparam logic [16:0] DIST_MAX = 17'd131071;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE, S_SKIP_LOAD, S_SKIP_CORDIC, S_SKIP_CHECK, S_TICK_CORDIC,
    S_TICK_ERR, S_TICK_DECIDE, S_MUL, S_FINISH, S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cordic_start;
    logic cordic_goal;
    logic skip_pop;
    logic skip_end;
    logic final_err;
    logic mul_start;
    logic do_lin;
    logic finish;
    logic goal_done;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cordic_done;
    logic fifo_empty;
    logic dist_below;
    logic dist_above;
    logic err_above;
    logic mul_done;
  } dp_stat_t;

  // Arctangent table in Q.16.
  function automatic logic [15:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0: atan_q16 = 16'd51472;
      5'd1: atan_q16 = 16'd30386;
      5'd2: atan_q16 = 16'd16055;
      5'd3: atan_q16 = 16'd8150;
      5'd4: atan_q16 = 16'd4091;
      5'd5: atan_q16 = 16'd2047;
      5'd6: atan_q16 = 16'd1024;
      5'd7: atan_q16 = 16'd512;
      5'd8: atan_q16 = 16'd256;
      5'd9: atan_q16 = 16'd128;
      5'd10: atan_q16 = 16'd64;
      5'd11: atan_q16 = 16'd32;
      5'd12: atan_q16 = 16'd16;
      5'd13: atan_q16 = 16'd8;
      5'd14: atan_q16 = 16'd4;
      5'd15: atan_q16 = 16'd2;
      5'd16: atan_q16 = 16'd1;
      default: atan_q16 = 16'd0;
    endcase
  endfunction

  // Wraps an angle error once into plus or minus pi.
  function automatic logic signed [16:0] wrap_once(input logic signed [16:0] a);
    if (a > 17'(PI_Q12)) begin
      wrap_once = a - 17'(TWO_PI_Q12);
    end else if (a < -17'(PI_Q12)) begin
      wrap_once = a + 17'(TWO_PI_Q12);
    end else begin
      wrap_once = a;
    end
  endfunction

endpackage

// ===== rtl/core/ddwp_ctrl.sv =====
// Controller state machine of the waypoint PID core.
// Depends on ddwp_pkg; drives the datapath by command and status structs.
`timescale 1ns / 1ps

module ddwp_ctrl import ddwp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [1:0] action,
  input  logic       list_last,
  input  logic       goal_valid,
  input  logic       out_busy,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       out_load
);

  state_t state, state_next;
  logic   is_lin, is_lin_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      is_lin  <= 1'b0;
    end else begin
      state   <= state_next;
      is_lin  <= is_lin_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next   = state;
    is_lin_next  = is_lin;
    cmd          = '0;
    out_load     = 1'b0;
    busy         = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (action == ACT_WAYPOINT && list_last) begin
            state_next = S_SKIP_LOAD;
          end else if (action == ACT_TICK && goal_valid) begin
            state_next = S_TICK_CORDIC;
            cmd.cordic_start = 1'b1;
            cmd.cordic_goal  = 1'b1;
          end
        end
      end
      // The FIFO write lands this cycle; head read is registered.
      S_SKIP_LOAD: begin
        if (stat.fifo_empty) begin
          cmd.skip_end = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_SKIP_CORDIC;
        end
      end
      S_SKIP_CORDIC: begin
        cmd.cordic_start = 1'b1;
        state_next       = S_SKIP_CHECK;
      end
      S_SKIP_CHECK: begin
        if (stat.cordic_done) begin
          if (stat.dist_below) begin
            cmd.skip_pop = 1'b1;
            state_next   = S_SKIP_LOAD;
          end else begin
            cmd.skip_end = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      S_TICK_CORDIC: begin
        if (stat.cordic_done) begin
          state_next = S_TICK_ERR;
        end
      end
      S_TICK_ERR: begin
        state_next = S_TICK_DECIDE;
      end
      S_TICK_DECIDE: begin
        if (stat.dist_above) begin
          is_lin_next   = !stat.err_above;
          cmd.mul_start = 1'b1;
          state_next    = S_MUL;
        end else begin
          cmd.final_err = 1'b1;
          is_lin_next   = 1'b0;
          state_next    = S_FINISH;
        end
      end
      S_FINISH: begin
        // Final heading error is registered; decide rotate or done.
        if (stat.err_above) begin
          cmd.mul_start = 1'b1;
          state_next    = S_MUL;
        end else begin
          cmd.goal_done = 1'b1;
          state_next    = S_OUT;
        end
      end
      S_MUL: begin
        cmd.do_lin = is_lin;
        if (stat.mul_done) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_busy) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/ddwp_datapath.sv =====
// Datapath of the waypoint PID core: pose, FIFO, CORDIC, PID arithmetic.
// Depends on ddwp_pkg; sequenced by ddwp_ctrl.
`timescale 1ns / 1ps

module ddwp_datapath import ddwp_pkg::*; #(
  parameter int FIFO_DEPTH   = FifoDepthDef,
  parameter int CORDIC_ITERS = CordicItersDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic        [1:0]  action,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [14:0] heading,
  input  logic               list_first,
  input  logic        [15:0] kp_lin,
  input  logic        [15:0] ki_lin,
  input  logic        [15:0] kd_lin,
  input  logic        [15:0] kp_ang,
  input  logic        [15:0] ki_ang,
  input  logic        [15:0] kd_ang,
  input  logic        [11:0] dist_threshold,
  input  logic        [11:0] angle_threshold,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               goal_valid,
  output logic signed [10:0] res_lin,
  output logic signed [13:0] res_ang,
  output logic        [1:0]  res_phase
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int IW = $clog2(CORDIC_ITERS + 1);

  // Pose and goal registers.
  logic signed [15:0] robot_x, robot_y;
  logic signed [14:0] robot_heading;
  logic signed [15:0] goal_x, goal_y;
  logic signed [14:0] goal_h;

  // Waypoint memory and pointers.
  logic [46:0] fifo_mem [FIFO_DEPTH];
  logic [46:0] head_word;
  logic [AW-1:0] fifo_head;
  logic [CW-1:0] fifo_count;
  logic [AW-1:0] head_next_ptr, wr_ptr;
  logic [AW:0]   wr_sum;

  always_comb begin
    wr_sum = {1'b0, fifo_head} + (AW+1)'(fifo_count);
    if (FIFO_DEPTH > 1 && wr_sum >= (AW+1)'(FIFO_DEPTH)) begin
      wr_sum = wr_sum - (AW+1)'(FIFO_DEPTH);
    end
    wr_ptr = wr_sum[AW-1:0];
    if (FIFO_DEPTH > 1 && fifo_head == AW'(FIFO_DEPTH - 1)) begin
      head_next_ptr = '0;
    end else if (FIFO_DEPTH > 1) begin
      head_next_ptr = fifo_head + 1'b1;
    end else begin
      head_next_ptr = '0;
    end
  end

  logic wp_in, wr_en;
  assign wp_in = in_fire && action == ACT_WAYPOINT;
  assign wr_en = wp_in && (list_first || fifo_count < CW'(FIFO_DEPTH));

  // Memory write and registered head read.
  logic [AW-1:0] wr_addr;
  assign wr_addr = list_first ? '0 : wr_ptr;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_mem[wr_addr] <= {pos_x, pos_y, heading};
    end
    head_word <= fifo_mem[fifo_head];
  end

  // Control state: pointers, goal flag, pose.
  logic pop;
  assign pop = cmd.skip_pop || ((cmd.skip_end || cmd.goal_done) && fifo_count != '0);
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_head  <= '0;
      fifo_count <= '0;
      goal_valid <= 1'b0;
      robot_x <= '0;
      robot_y <= '0;
      robot_heading <= '0;
      goal_x <= '0;
      goal_y <= '0;
      goal_h <= '0;
    end else begin
      if (in_fire && action == ACT_POSE) begin
        robot_x <= pos_x;
        robot_y <= pos_y;
        robot_heading <= heading;
      end
      if (wp_in) begin
        if (list_first) begin
          fifo_head  <= '0;
          fifo_count <= CW'(1);
        end else if (wr_en) begin
          fifo_count <= fifo_count + 1'b1;
        end
      end else if (pop) begin
        fifo_head  <= head_next_ptr;
        fifo_count <= fifo_count - 1'b1;
      end
      if (cmd.skip_end || cmd.goal_done) begin
        goal_valid <= (fifo_count != '0);
        if (fifo_count != '0) begin
          goal_x <= head_word[46:31];
          goal_y <= head_word[30:15];
          goal_h <= head_word[14:0];
        end
      end
    end
  end

  // Iterative CORDIC, one vectoring step a cycle.
  logic signed [30:0] cx, cy;
  logic signed [21:0] cz;
  logic [IW-1:0] citer;
  logic cbusy, cdone;
  logic signed [16:0] dx, dy;
  logic signed [30:0] xs, ys;
  always_comb begin
    if (cmd.cordic_goal) begin
      dx = 17'(goal_x) - 17'(robot_x);
      dy = 17'(goal_y) - 17'(robot_y);
    end else begin
      dx = 17'(signed'(head_word[46:31])) - 17'(robot_x);
      dy = 17'(signed'(head_word[30:15])) - 17'(robot_y);
    end
    xs = cx >>> citer;
    ys = cy >>> citer;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cbusy <= 1'b0;
      cdone <= 1'b0;
      citer <= '0;
    end else begin
      cdone <= 1'b0;
      if (cmd.cordic_start) begin
        cbusy <= 1'b1;
        citer <= '0;
      end else if (cbusy) begin
        if (citer == IW'(CORDIC_ITERS - 1)) begin
          cbusy <= 1'b0;
          cdone <= 1'b1;
        end
        citer <= citer + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cordic_start) begin
      if (dx < 0) begin
        if (dy >= 0) begin
          cx <= 31'(dy) <<< 12;
          cy <= (-31'(dx)) <<< 12;
          cz <= HALF_PI_Q16;
        end else begin
          cx <= (-31'(dy)) <<< 12;
          cy <= 31'(dx) <<< 12;
          cz <= -HALF_PI_Q16;
        end
      end else begin
        cx <= 31'(dx) <<< 12;
        cy <= 31'(dy) <<< 12;
        cz <= '0;
      end
    end else if (cbusy) begin
      if (cy >= 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + 22'(atan_q16(5'(citer)));
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - 22'(atan_q16(5'(citer)));
      end
    end
  end

  // Distance scaling, registered after the multiply.
  logic signed [47:0] dprod;
  logic [16:0] dist_val;
  logic signed [19:0] dsh;
  always_ff @(posedge clk) begin
    dprod <= cx * $signed({1'b0, INV_GAIN_Q16});
  end
  assign dsh = 20'((dprod + 48'sd134217728) >>> 28);
  always_comb begin
    if (dsh < 0) begin
      dist_val = '0;
    end else if (dsh > 20'(DIST_MAX)) begin
      dist_val = DIST_MAX;
    end else begin
      dist_val = dsh[16:0];
    end
  end
  logic dist_valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else begin
      dist_valid <= cdone;
    end
  end

  // Bearing error and heading error.
  logic signed [16:0] bear, err, err_abs, ferr;
  assign bear = 17'((cz + 22'sd8) >>> 4);
  logic signed [16:0] err_w;
  assign err_w = wrap_once(bear - 17'(robot_heading));
  assign ferr  = wrap_once(17'(goal_h) - 17'(robot_heading));
  always_ff @(posedge clk) begin
    if (dist_valid) begin
      err <= err_w;
    end else if (cmd.final_err) begin
      err <= ferr;
    end
  end
  assign err_abs = (err < 0) ? -err : err;
  logic [16:0] dist_r;
  always_ff @(posedge clk) begin
    if (dist_valid) begin
      dist_r <= dist_val;
    end
  end

  // PID state.
  logic signed [20:0] ang_int, lin_int;
  logic signed [16:0] ang_prev;
  logic signed [17:0] lin_prev;

  // Serial multiply sequencer: one product a cycle, accumulated.
  logic [3:0] mstep;
  logic mbusy, mdone;
  logic signed [16:0] ma;
  logic signed [33:0] mb;
  logic signed [50:0] mprod;
  logic signed [51:0] acc_a, acc_l;
  logic signed [20:0] ang_int_new, lin_int_new;
  logic signed [33:0] ang_tmp, lin_tmp;

  // Status.
  assign stat.cordic_done = dist_valid;
  assign stat.fifo_empty  = (fifo_count == '0);
  assign stat.dist_below  = dist_val < 17'(dist_threshold);
  assign stat.dist_above  = dist_r > 17'(dist_threshold);
  assign stat.err_above   = err_abs > 17'(angle_threshold);
  assign stat.mul_done    = mdone;

  always_comb begin
    ang_tmp = 34'(err) * 34'(DT_Q16);
    ang_int_new = 21'(ang_int) + 21'((ang_tmp + 34'sd2048) >>> 12);
    if (ang_int_new > ILIM_ANG) ang_int_new = ILIM_ANG;
    else if (ang_int_new < -ILIM_ANG) ang_int_new = -ILIM_ANG;
    lin_tmp = 34'($signed({1'b0, dist_r})) * 34'(DT_Q16);
    lin_int_new = 21'(lin_int) + 21'((lin_tmp + 34'sd2048) >>> 12);
    if (lin_int_new > ILIM_LIN) lin_int_new = ILIM_LIN;
    else if (lin_int_new < -ILIM_LIN) lin_int_new = -ILIM_LIN;
    ma = '0;
    mb = '0;
    case (mstep)
      4'd0: begin ma = $signed({1'b0, kp_ang}); mb = 34'(err) <<< 4; end
      4'd1: begin ma = $signed({1'b0, ki_ang}); mb = 34'(ang_int); end
      4'd2: begin
        ma = $signed({1'b0, kd_ang});
        mb = (34'(err) - 34'(ang_prev)) * 34'sd320;
      end
      4'd3: begin
        ma = $signed({1'b0, kp_lin});
        mb = 34'($signed({1'b0, dist_r})) <<< 4;
      end
      4'd4: begin ma = $signed({1'b0, ki_lin}); mb = 34'(lin_int); end
      4'd5: begin
        ma = $signed({1'b0, kd_lin});
        mb = (34'($signed({1'b0, dist_r})) - 34'(lin_prev)) * 34'sd320;
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    mprod <= ma * mb;
  end

  logic [3:0] pstep;
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
      mstep <= '0;
      pstep <= '0;
      acc_a <= '0;
      acc_l <= '0;
      ang_int <= '0;
      lin_int <= '0;
      ang_prev <= '0;
      lin_prev <= '0;
    end else begin
      mdone <= 1'b0;
      if (cmd.mul_start) begin
        mbusy <= 1'b1;
        mstep <= '0;
        pstep <= 4'd15;
        acc_a <= '0;
        acc_l <= '0;
        ang_int <= ang_int_new;
      end else if (mbusy) begin
        // Step one uses the updated integral, already registered.
        pstep <= mstep;
        if (mstep < 4'd6) mstep <= mstep + 1'b1;
        if (pstep < 4'd3) acc_a <= acc_a + 52'(mprod);
        else if (pstep < 4'd6) acc_l <= acc_l + 52'(mprod);
        if (mstep == 4'd3 && !cmd.do_lin) begin
          mbusy <= 1'b0;
          mdone <= 1'b1;
        end else if (pstep == 4'd5) begin
          mbusy <= 1'b0;
          mdone <= 1'b1;
        end
        if (mstep == 4'd2 && cmd.do_lin) lin_int <= lin_int_new;
      end
      if (cmd.finish) begin
        ang_prev <= err;
        if (cmd.do_lin) lin_prev <= $signed({1'b0, dist_r});
      end
      if (cmd.goal_done) begin
        ang_int <= '0;
        lin_int <= '0;
        ang_prev <= '0;
        lin_prev <= '0;
      end
    end
  end

  // Rounding, clamping and result registers.
  logic signed [51:0] ra, rl;
  assign ra = (acc_a + 52'sd32768) >>> 16;
  assign rl = (acc_l + 52'sd8192) >>> 14;
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_ang <= (ra > 52'sd4096) ? 14'sd4096 : (ra < -52'sd4096) ? -14'sd4096 : 14'(ra);
      if (cmd.do_lin) begin
        res_lin <= (rl > 52'sd819) ? 11'sd819 : (rl < -52'sd819) ? -11'sd819 : 11'(rl);
        res_phase <= PH_DRIVE;
      end else begin
        res_lin <= '0;
        res_phase <= stat.dist_above ? PH_TURN : PH_ROTATE;
      end
    end else if (cmd.goal_done) begin
      res_ang <= '0;
      res_lin <= '0;
      res_phase <= PH_DONE;
    end
  end

endmodule

// ===== rtl/core/diff_drive_waypoint_pid_core.sv =====
// Top level of the waypoint PID core: ports, register file, output word.
// Depends on ddwp_pkg, ddwp_ctrl and ddwp_datapath.
//
//  channel  | handshake              | payload
//  in       | in_valid / in_ready    | action pos_x pos_y heading list_first list_last
//  out      | out_valid / out_ready  | linear_cmd angular_cmd phase goal_active
//  apb      | psel penable pwrite    | paddr pwdata prdata
//
// A drive tick runs the serial CORDIC and the six-product multiply sequence; a turn
// tick and a final rotate tick run the CORDIC and the three angular products, and a
// goal-reached tick runs the CORDIC only. A list end runs the CORDIC once per waypoint
// examined. Reset is synchronous. A word waiting in the output register holds the
// next tick in its output state, and no input is taken until then.
`timescale 1ns / 1ps

module diff_drive_waypoint_pid_core import ddwp_pkg::*; #(
  parameter int FIFO_DEPTH   = FifoDepthDef,
  parameter int CORDIC_ITERS = CordicItersDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [1:0]  action,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [14:0] heading,
  input  logic               list_first,
  input  logic               list_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [10:0] linear_cmd,
  output logic signed [13:0] angular_cmd,
  output logic        [1:0]  phase,
  output logic               goal_active,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [4:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  logic [15:0] kp_lin, ki_lin, kd_lin, kp_ang, ki_ang, kd_ang;
  logic [11:0] dist_threshold, angle_threshold;
  logic [2:0]  reg_idx;

  // Register file.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_lin <= 16'd6144;
      ki_lin <= 16'd0;
      kd_lin <= 16'd0;
      kp_ang <= 16'd14336;
      ki_ang <= 16'd0;
      kd_ang <= 16'd410;
      dist_threshold  <= 12'd51;
      angle_threshold <= 12'd307;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (reg_idx)
        REG_KP_LIN: kp_lin <= pwdata[15:0];
        REG_KI_LIN: ki_lin <= pwdata[15:0];
        REG_KD_LIN: kd_lin <= pwdata[15:0];
        REG_KP_ANG: kp_ang <= pwdata[15:0];
        REG_KI_ANG: ki_ang <= pwdata[15:0];
        REG_KD_ANG: kd_ang <= pwdata[15:0];
        REG_DIST_TH: dist_threshold <= pwdata[11:0];
        REG_ANG_TH: angle_threshold <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      REG_KP_LIN: prdata = 32'(kp_lin);
      REG_KI_LIN: prdata = 32'(ki_lin);
      REG_KD_LIN: prdata = 32'(kd_lin);
      REG_KP_ANG: prdata = 32'(kp_ang);
      REG_KI_ANG: prdata = 32'(ki_ang);
      REG_KD_ANG: prdata = 32'(kd_ang);
      REG_DIST_TH: prdata = 32'(dist_threshold);
      REG_ANG_TH: prdata = 32'(angle_threshold);
      default: prdata = '0;
    endcase
  end

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic busy, out_load, in_fire, goal_valid;
  logic signed [10:0] res_lin;
  logic signed [13:0] res_ang;
  logic [1:0] res_phase;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;

  ddwp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .action(action),
    .list_last(list_last), .goal_valid(goal_valid),
    .out_busy(out_valid && !out_ready), .stat(stat), .cmd(cmd),
    .busy(busy), .out_load(out_load)
  );

  ddwp_datapath #(.FIFO_DEPTH(FIFO_DEPTH), .CORDIC_ITERS(CORDIC_ITERS)) u_dp (
    .clk(clk), .rst(rst), .in_fire(in_fire), .action(action),
    .pos_x(pos_x), .pos_y(pos_y), .heading(heading), .list_first(list_first),
    .kp_lin(kp_lin), .ki_lin(ki_lin), .kd_lin(kd_lin),
    .kp_ang(kp_ang), .ki_ang(ki_ang), .kd_ang(kd_ang),
    .dist_threshold(dist_threshold), .angle_threshold(angle_threshold),
    .cmd(cmd), .stat(stat), .goal_valid(goal_valid),
    .res_lin(res_lin), .res_ang(res_ang), .res_phase(res_phase)
  );

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (out_load) begin
      linear_cmd  <= res_lin;
      angular_cmd <= res_ang;
      phase       <= res_phase;
      goal_active <= goal_valid;
    end
  end

  // A result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(out_valid && !out_ready))
    else $error("output word overwritten");

  // No input is taken while a word is in flight inside the core.
  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_fire)
    else $error("input taken while busy");

  // The goal-reached phase always carries zero commands.
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase == PH_DONE) |-> (linear_cmd == 0 && angular_cmd == 0))
    else $error("nonzero command at goal reached");

endmodule
